FILE: rtl/ccv_pkg.sv
`default_nettype none
package ccv_pkg;

  typedef logic [4:0] mode_t;

  // conversion paths
  localparam mode_t MODE_RGB_GRAY  = 5'd0;
  localparam mode_t MODE_RGB_565   = 5'd1;
  localparam mode_t MODE_RGB_YUV   = 5'd2;
  localparam mode_t MODE_RGB_HSV   = 5'd3;
  localparam mode_t MODE_565_RGB   = 5'd4;
  localparam mode_t MODE_565_GRAY  = 5'd5;
  localparam mode_t MODE_565_YUV   = 5'd6;
  localparam mode_t MODE_565_HSV   = 5'd7;
  localparam mode_t MODE_GRAY_RGB  = 5'd8;
  localparam mode_t MODE_GRAY_565  = 5'd9;
  localparam mode_t MODE_GRAY_YUV  = 5'd10;
  localparam mode_t MODE_GRAY_HSV  = 5'd11;
  localparam mode_t MODE_YUV_RGB   = 5'd12;
  localparam mode_t MODE_YUV_565   = 5'd13;
  localparam mode_t MODE_YUV_GRAY  = 5'd14;
  localparam mode_t MODE_YUV_HSV   = 5'd15;
  localparam mode_t MODE_HSV_RGB   = 5'd16;
  localparam mode_t MODE_HSV_565   = 5'd17;
  localparam mode_t MODE_HSV_GRAY  = 5'd18;
  localparam mode_t MODE_HSV_YUV   = 5'd19;
  localparam mode_t MODE_COPY      = 5'd20;

  typedef enum logic [2:0] {
    KIND_RGB,
    KIND_565,
    KIND_GRAY,
    KIND_YUV,
    KIND_HSV
  } kind_t;

  typedef struct packed {
    logic [7:0]  ch0;
    logic [7:0]  ch1;
    logic [7:0]  ch2;
    logic [15:0] pk;
    logic        last;
  } pix_t;

  typedef struct packed {
    pix_t  pix;
    mode_t mode;
  } item_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // reciprocal constants: floor(n/d) == (n*K) >> SH over the ranges used
  localparam logic [18:0] K_DIV1000  = 19'd268436;    // shift 28, n < 256000
  localparam logic [25:0] K_DIV100K  = 26'd43980466;  // shift 42, n < 2^25
  localparam logic [24:0] K_DIV65025 = 25'd16909061;  // shift 40, n <= 255*65025

  function automatic kind_t src_kind(input mode_t m);
    kind_t k;
    unique case (m) inside
      MODE_565_RGB, MODE_565_GRAY, MODE_565_YUV, MODE_565_HSV:     k = KIND_565;
      MODE_GRAY_RGB, MODE_GRAY_565, MODE_GRAY_YUV, MODE_GRAY_HSV: k = KIND_GRAY;
      MODE_YUV_RGB, MODE_YUV_565, MODE_YUV_GRAY, MODE_YUV_HSV:     k = KIND_YUV;
      MODE_HSV_RGB, MODE_HSV_565, MODE_HSV_GRAY, MODE_HSV_YUV:     k = KIND_HSV;
      default:                                                     k = KIND_RGB;
    endcase
    return k;
  endfunction

  function automatic kind_t dst_kind(input mode_t m);
    kind_t k;
    unique case (m) inside
      MODE_RGB_GRAY, MODE_565_GRAY, MODE_YUV_GRAY, MODE_HSV_GRAY: k = KIND_GRAY;
      MODE_RGB_565, MODE_GRAY_565, MODE_YUV_565, MODE_HSV_565:    k = KIND_565;
      MODE_RGB_YUV, MODE_565_YUV, MODE_GRAY_YUV, MODE_HSV_YUV:    k = KIND_YUV;
      MODE_RGB_HSV, MODE_565_HSV, MODE_GRAY_HSV, MODE_YUV_HSV:    k = KIND_HSV;
      default:                                                    k = KIND_RGB;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ccv_in_if.sv
`default_nettype none
interface ccv_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  in_ch0;
  logic [7:0]  in_ch1;
  logic [7:0]  in_ch2;
  logic [15:0] in_packed;
  logic        in_last;

  modport source(output valid, in_ch0, in_ch1, in_ch2, in_packed, in_last, input ready);
  modport sink(input valid, in_ch0, in_ch1, in_ch2, in_packed, in_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/ccv_out_if.sv
`default_nettype none
interface ccv_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_ch0;
  logic [7:0]  out_ch1;
  logic [7:0]  out_ch2;
  logic [15:0] out_packed;
  logic        out_last;

  modport source(output valid, out_ch0, out_ch1, out_ch2, out_packed, out_last,
                 input ready);
  modport sink(input valid, out_ch0, out_ch1, out_ch2, out_packed, out_last,
               output ready);
endinterface
`default_nettype wire

FILE: rtl/ccv_div.sv
`default_nettype none
module ccv_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 17,
  parameter int Q_W   = 8
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [Q_W-1:0]   quo
);
  // restoring divider, one quotient bit per stage; num < den << Q_W
  localparam int W = NUM_W + Q_W;

  logic [NUM_W-1:0] rem [Q_W+1];
  logic [DEN_W-1:0] dv  [Q_W+1];
  logic [Q_W-1:0]   qb  [Q_W+1];

  assign rem[0] = num;
  assign dv[0]  = den;
  assign qb[0]  = '0;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [W-1:0] trial;
    logic         ge;
    assign trial = W'(dv[i]) << (Q_W - 1 - i);
    assign ge    = W'(rem[i]) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? NUM_W'(W'(rem[i]) - trial) : rem[i];
        dv[i+1]  <= dv[i];
        qb[i+1]  <= {qb[i][Q_W-2:0], ge};
      end
    end
  end

  assign quo = qb[Q_W];
endmodule
`default_nettype wire

FILE: rtl/ccv_decode.sv
`default_nettype none
module ccv_decode
  import ccv_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_v,
  input  wire item_t in_item,
  output logic       out_v,
  output item_t      out_item,
  output rgb_t       out_rgb
);
  // stage 1 registers
  logic               v1;
  item_t              it1;
  rgb_t               dir1;
  logic signed [20:0] n1 [3];
  logic [2:0]         sec1;
  logic [7:0]         val1;
  logic [15:0]        smid1, slo1;
  // stage 2 registers
  logic               v2;
  item_t              it2;
  rgb_t               dir2;
  logic [17:0]        yc2 [3];
  logic [2:0]         sec2;
  logic [7:0]         val2;
  logic [23:0]        pmid2, plo2;
  // stage 3 registers
  logic               v3;
  item_t              it3;
  rgb_t               dir3;
  logic [36:0]        yp3 [3];
  logic [2:0]         sec3;
  logic [7:0]         val3;
  logic [48:0]        hmid3, hlo3;

  // stage 1 logic
  kind_t              sk;
  rgb_t               dir_c;
  logic signed [20:0] ys, ups, vps;
  logic [7:0]         h, s;
  logic [2:0]         sec_c;
  logic [1:0]         pair_c;
  logic [10:0]        f_c;
  logic [7:0]         k_c;

  always_comb begin
    sk = src_kind(in_item.mode);
    case (sk)
      KIND_565: dir_c = '{r: {in_item.pix.pk[15:11], in_item.pix.pk[15:13]},
                          g: {in_item.pix.pk[10:5], in_item.pix.pk[10:9]},
                          b: {in_item.pix.pk[4:0], in_item.pix.pk[4:2]}};
      KIND_GRAY: dir_c = '{r: in_item.pix.ch0, g: in_item.pix.ch0, b: in_item.pix.ch0};
      default: dir_c = '{r: in_item.pix.ch0, g: in_item.pix.ch1, b: in_item.pix.ch2};
    endcase
    ys  = signed'({13'd0, in_item.pix.ch0});
    ups = signed'({13'd0, in_item.pix.ch1}) - 21'sd128;
    vps = signed'({13'd0, in_item.pix.ch2}) - 21'sd128;
    // hue sextant and distance from the middle of its sextant pair
    h = in_item.pix.ch0;
    s = in_item.pix.ch1;
    if (h >= 8'd213)      sec_c = 3'd5;
    else if (h >= 8'd170) sec_c = 3'd4;
    else if (h >= 8'd128) sec_c = 3'd3;
    else if (h >= 8'd85)  sec_c = 3'd2;
    else if (h >= 8'd43)  sec_c = 3'd1;
    else                  sec_c = 3'd0;
    if (h == 8'd255)      pair_c = 2'd3;
    else if (h >= 8'd170) pair_c = 2'd2;
    else if (h >= 8'd85)  pair_c = 2'd1;
    else                  pair_c = 2'd0;
    f_c = 11'({3'd0, h} * 11'd6) - 11'({9'd0, pair_c} * 11'd510);
    k_c = (f_c >= 11'd255) ? 8'(f_c - 11'd255) : 8'(11'd255 - f_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1    <= in_item;
      dir1   <= dir_c;
      n1[0]  <= 21'sd1000 * ys + 21'sd1403 * vps;
      n1[1]  <= 21'sd1000 * ys - 21'sd344 * ups - 21'sd714 * vps;
      n1[2]  <= 21'sd1000 * ys + 21'sd1770 * ups;
      sec1   <= sec_c;
      val1   <= in_item.pix.ch2;
      smid1  <= {8'd0, s} * {8'd0, k_c};
      slo1   <= {8'd0, s} * 16'd255;
    end
  end

  // stage 2: clip sums into the reciprocal range, scale value
  function automatic logic [17:0] clip_n(input logic signed [20:0] n);
    logic [17:0] r;
    if (n < 0)                 r = '0;
    else if (n > 21'sd255999)  r = 18'd255999;
    else                       r = n[17:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      it2    <= it1;
      dir2   <= dir1;
      for (int i = 0; i < 3; i++) yc2[i] <= clip_n(n1[i]);
      sec2   <= sec1;
      val2   <= val1;
      pmid2  <= {16'd0, val1} * {8'd0, 16'd65025 - smid1};
      plo2   <= {16'd0, val1} * {8'd0, 16'd65025 - slo1};
    end
  end

  // stage 3: reciprocal products
  always_ff @(posedge clk) begin
    if (en) begin
      it3    <= it2;
      dir3   <= dir2;
      for (int i = 0; i < 3; i++) yp3[i] <= {19'd0, yc2[i]} * {18'd0, K_DIV1000};
      sec3   <= sec2;
      val3   <= val2;
      hmid3  <= {25'd0, pmid2} * {24'd0, K_DIV65025};
      hlo3   <= {25'd0, plo2} * {24'd0, K_DIV65025};
    end
  end

  // stage 4: pick the decoded color
  rgb_t       rgb_c;
  logic [7:0] hi, mid, lo;

  always_comb begin
    hi  = val3;
    mid = hmid3[47:40];
    lo  = hlo3[47:40];
    case (src_kind(it3.mode))
      KIND_YUV: rgb_c = '{r: yp3[0][35:28], g: yp3[1][35:28], b: yp3[2][35:28]};
      KIND_HSV: begin
        case (sec3)
          3'd0:    rgb_c = '{r: hi,  g: mid, b: lo};
          3'd1:    rgb_c = '{r: mid, g: hi,  b: lo};
          3'd2:    rgb_c = '{r: lo,  g: hi,  b: mid};
          3'd3:    rgb_c = '{r: lo,  g: mid, b: hi};
          3'd4:    rgb_c = '{r: mid, g: lo,  b: hi};
          default: rgb_c = '{r: hi,  g: lo,  b: mid};
        endcase
      end
      default: rgb_c = dir3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= it3;
      out_rgb  <= rgb_c;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1    <= in_v;
      v2    <= v1;
      v3    <= v2;
      out_v <= v3;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ccv_encode.sv
`default_nettype none
module ccv_encode
  import ccv_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  in_v,
  input  wire item_t in_item,
  input  wire rgb_t  in_rgb,
  output logic       out_v,
  output pix_t       out_pix
);
  localparam int DIV_Q = 8;
  localparam int LINE  = DIV_Q - 1;

  typedef struct packed {
    item_t       item;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [15:0] pk;
    logic        hz;
    logic        sz;
    logic [7:0]  mx;
  } res_t;

  // stage 1 registers
  logic        v1;
  item_t       it1;
  rgb_t        rgb1;
  logic [17:0] gs1;
  logic [24:0] ym1, um1, vm1;
  logic        un1, vn1;
  logic        hz1, sz1;
  logic [7:0]  mx1;
  logic [24:0] hnum1;
  logic [16:0] hden1;
  logic [15:0] snum1;
  // stage 2 registers
  logic        v2;
  item_t       it2;
  rgb_t        rgb2;
  logic [36:0] gp2;
  logic [50:0] yp2, up2, vp2;
  logic        un2, vn2;
  logic        hz2, sz2;
  logic [7:0]  mx2;
  // delay line
  logic        lv [LINE];
  res_t        line [LINE];

  // stage 1: weighted sums and hsv operands
  logic signed [25:0] rs, gsg, bs, us, vs;
  logic [7:0]         mx, mn, dl;
  logic signed [18:0] hn, dls;

  always_comb begin
    rs  = signed'({18'd0, in_rgb.r});
    gsg = signed'({18'd0, in_rgb.g});
    bs  = signed'({18'd0, in_rgb.b});
    us  = 26'sd43600 * bs - 26'sd14713 * rs - 26'sd28886 * gsg;
    vs  = 26'sd61500 * rs - 26'sd51499 * gsg - 26'sd10001 * bs;
    mx = in_rgb.r;
    if (in_rgb.g > mx) mx = in_rgb.g;
    if (in_rgb.b > mx) mx = in_rgb.b;
    mn = in_rgb.r;
    if (in_rgb.g < mn) mn = in_rgb.g;
    if (in_rgb.b < mn) mn = in_rgb.b;
    dl  = mx - mn;
    dls = signed'({11'd0, dl});
    // hue numerator, R sextant wins ties, then G
    if (mx == in_rgb.r) begin
      hn = 19'sd60 * (signed'({11'd0, in_rgb.g}) - signed'({11'd0, in_rgb.b}));
      if (in_rgb.g < in_rgb.b) hn = hn + 19'sd360 * dls;
    end else if (mx == in_rgb.g) begin
      hn = 19'sd60 * (signed'({11'd0, in_rgb.b}) - signed'({11'd0, in_rgb.r}))
         + 19'sd120 * dls;
    end else begin
      hn = 19'sd60 * (signed'({11'd0, in_rgb.r}) - signed'({11'd0, in_rgb.g}))
         + 19'sd240 * dls;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1   <= in_item;
      rgb1  <= in_rgb;
      gs1   <= 18'd299 * {10'd0, in_rgb.r} + 18'd587 * {10'd0, in_rgb.g}
             + 18'd114 * {10'd0, in_rgb.b};
      ym1   <= 25'd29900 * {17'd0, in_rgb.r} + 25'd58700 * {17'd0, in_rgb.g}
             + 25'd11400 * {17'd0, in_rgb.b} + 25'd50000;
      um1   <= 25'(us < 0 ? -us : us) + 25'd50000;
      vm1   <= 25'(vs < 0 ? -vs : vs) + 25'd50000;
      un1   <= us < 0;
      vn1   <= vs < 0;
      hz1   <= dl == 8'd0;
      sz1   <= mx == 8'd0;
      mx1   <= mx;
      hnum1 <= {8'd0, hn[16:0]} * 25'd255;
      hden1 <= {9'd0, dl} * 17'd360;
      snum1 <= {8'd0, dl} * 16'd255;
    end
  end

  // hue and saturation dividers
  logic [DIV_Q-1:0] hq, sq;

  ccv_div #(.NUM_W(25), .DEN_W(17), .Q_W(DIV_Q)) u_hue_div (
    .clk (clk), .en (en), .num (hnum1), .den (hden1), .quo (hq)
  );

  ccv_div #(.NUM_W(16), .DEN_W(8), .Q_W(DIV_Q)) u_sat_div (
    .clk (clk), .en (en), .num (snum1), .den (mx1), .quo (sq)
  );

  // stage 2: reciprocal products
  always_ff @(posedge clk) begin
    if (en) begin
      it2  <= it1;
      rgb2 <= rgb1;
      gp2  <= {19'd0, gs1} * {18'd0, K_DIV1000};
      yp2  <= {26'd0, ym1} * {25'd0, K_DIV100K};
      up2  <= {26'd0, um1} * {25'd0, K_DIV100K};
      vp2  <= {26'd0, vm1} * {25'd0, K_DIV100K};
      un2  <= un1;
      vn2  <= vn1;
      hz2  <= hz1;
      sz2  <= sz1;
      mx2  <= mx1;
    end
  end

  // stage 3: finish non-hsv targets
  function automatic logic [7:0] chroma(input logic [8:0] q, input logic neg);
    logic signed [10:0] t;
    logic [7:0]         r;
    t = neg ? (11'sd128 - signed'({2'd0, q})) : (11'sd128 + signed'({2'd0, q}));
    if (t < 0)              r = 8'd0;
    else if (t > 11'sd255)  r = 8'd255;
    else                    r = t[7:0];
    return r;
  endfunction

  res_t res_c;

  always_comb begin
    res_c      = '0;
    res_c.item = it2;
    res_c.hz   = hz2;
    res_c.sz   = sz2;
    res_c.mx   = mx2;
    case (dst_kind(it2.mode))
      KIND_RGB: begin
        res_c.c0 = rgb2.r;
        res_c.c1 = rgb2.g;
        res_c.c2 = rgb2.b;
      end
      KIND_565:  res_c.pk = {rgb2.r[7:3], rgb2.g[7:2], rgb2.b[7:3]};
      KIND_GRAY: res_c.c0 = gp2[35:28];
      KIND_YUV: begin
        res_c.c0 = yp2[49:42];
        res_c.c1 = chroma(up2[50:42], un2);
        res_c.c2 = chroma(vp2[50:42], vn2);
      end
      default: ;
    endcase
  end

  // delay line to meet the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= res_c;
      for (int i = 1; i < LINE; i++) line[i] <= line[i-1];
    end
  end

  // final word
  pix_t  fin_c;
  res_t  tl;

  always_comb begin
    tl       = line[LINE-1];
    fin_c    = '0;
    fin_c.last = tl.item.pix.last;
    if (tl.item.mode == MODE_COPY) begin
      fin_c = tl.item.pix;
    end else if (tl.item.mode < MODE_COPY) begin
      if (dst_kind(tl.item.mode) == KIND_HSV) begin
        fin_c.ch0 = tl.hz ? 8'd0 : hq;
        fin_c.ch1 = tl.sz ? 8'd0 : sq;
        fin_c.ch2 = tl.mx;
      end else begin
        fin_c.ch0 = tl.c0;
        fin_c.ch1 = tl.c1;
        fin_c.ch2 = tl.c2;
        fin_c.pk  = tl.pk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_pix <= fin_c;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      for (int i = 0; i < LINE; i++) lv[i] <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1    <= in_v;
      v2    <= v1;
      lv[0] <= v2;
      for (int i = 1; i < LINE; i++) lv[i] <= lv[i-1];
      out_v <= lv[LINE-1];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/pixel_color_space_converter_top.sv
// throughput: one pixel per cycle unless the output stalls;
// the 8-stage hue and saturation dividers and the 15-register
// pipeline all advance together on one enable
// a stalled output freezes the whole pipeline until the word is taken
// reset (rst, synchronous) clears all valid bits and sets the mode to 0
`default_nettype none
module pixel_color_space_converter_top
  import ccv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  ccv_in_if.sink          in_pix,
  ccv_out_if.source       out_pix,
  input  wire logic       cfg_wr_en,
  input  wire logic [4:0] cfg_wr_data
);
  mode_t conv_mode;
  logic  en;
  logic  s0_v;
  item_t s0_item;
  logic  d_v;
  item_t d_item;
  rgb_t  d_rgb;
  logic  o_v;
  pix_t  o_pix;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      conv_mode <= MODE_RGB_GRAY;
    end else if (cfg_wr_en) begin
      conv_mode <= cfg_wr_data;
    end
  end

  // pipeline moves unless the output word is stuck
  assign en           = !o_v || out_pix.ready;
  assign in_pix.ready = en;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_item <= '{pix: '{ch0: in_pix.in_ch0, ch1: in_pix.in_ch1, ch2: in_pix.in_ch2,
                          pk: in_pix.in_packed, last: in_pix.in_last},
                   mode: conv_mode};
    end
  end

  ccv_decode u_dec (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (s0_v),
    .in_item  (s0_item),
    .out_v    (d_v),
    .out_item (d_item),
    .out_rgb  (d_rgb)
  );

  ccv_encode u_enc (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (d_v),
    .in_item (d_item),
    .in_rgb  (d_rgb),
    .out_v   (o_v),
    .out_pix (o_pix)
  );

  // output word
  assign out_pix.valid      = o_v;
  assign out_pix.out_ch0    = o_pix.ch0;
  assign out_pix.out_ch1    = o_pix.ch1;
  assign out_pix.out_ch2    = o_pix.ch2;
  assign out_pix.out_packed = o_pix.pk;
  assign out_pix.out_last   = o_pix.last;
endmodule
`default_nettype wire
